>>> sv/pett_pkg.sv
`default_nettype none

package pett_pkg;

    localparam int unsigned DEF_SLOTS       = 8;
    localparam int unsigned DEF_COUNT_WIDTH = 32;

    localparam int unsigned MODE_W     = 2;
    localparam int unsigned PERIOD_W   = 32;
    localparam int unsigned SLOT_ID_W  = 4;
    localparam int unsigned FIRED_W    = 8;
    localparam int unsigned ASSIGNED_W = 3;
    localparam int unsigned ACTIVE_W   = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK      = 2'd0,
        MODE_SET       = 2'd1,
        MODE_CLEAR     = 2'd2,
        MODE_CLEAR_ALL = 2'd3
    } mode_t;

    typedef struct packed {
        logic load;
        logic step;
    } pett_tmr_ctl_t;

endpackage

`default_nettype wire

>>> sv/pett_timer_unit.sv
`default_nettype none

module pett_timer_unit
    import pett_pkg::*;
#(
    parameter int unsigned SLOTS       = DEF_SLOTS,
    parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int unsigned IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                   clk,
    input  wire pett_tmr_ctl_t          ctl,
    input  wire logic [IDX_W-1:0]       idx,
    input  wire logic [COUNT_WIDTH-1:0] period,
    output logic                        hit
);

    logic [COUNT_WIDTH-1:0] reload_reg [SLOTS];
    logic [COUNT_WIDTH-1:0] count_reg  [SLOTS];
    logic [COUNT_WIDTH-1:0] dec;

    // One shared decrementer serves the slot under the sweep index.
    assign dec = count_reg[idx] - COUNT_WIDTH'(1);
    assign hit = (dec == '0);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            reload_reg[idx] <= period;
            count_reg[idx]  <= period;
        end
        else if (ctl.step)
        begin
            count_reg[idx] <= hit ? reload_reg[idx] : dec;
        end
    end

endmodule

`default_nettype wire

>>> sv/periodic_event_timer_table.sv
`default_nettype none

// Table of SLOTS periodic timers with one request per result. A request is
// taken only while the sequencer is idle; a tick or set then walks the slots
// one per cycle through a single shared decrement-and-compare unit. A tick
// with at least one active slot visits every slot, a set request stops at the
// lowest free slot or at the last slot when the table is full, and clear,
// clear-all and ticks on an empty table go straight to the result. The
// result sits in an output register, so a new request can be accepted while
// the previous result is still waiting to be taken.
module periodic_event_timer_table
    import pett_pkg::*;
#(
    parameter int unsigned SLOTS       = DEF_SLOTS,
    parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [PERIOD_W-1:0]   period,
    input  wire logic [SLOT_ID_W-1:0]  slot,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [FIRED_W-1:0]         fired_mask,
    output logic [ASSIGNED_W-1:0]      assigned_slot,
    output logic                       table_full,
    output logic [ACTIVE_W-1:0]        active_slots
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] period_reg, period_next;
    logic [SLOT_ID_W-1:0]   slot_reg, slot_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [SLOTS-1:0]       active_reg, active_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [FIRED_W-1:0]     fired_reg, fired_next;
    logic [ASSIGNED_W-1:0]  assigned_reg, assigned_next;
    logic                   full_reg, full_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FIRED_W-1:0]     out_fired_reg, out_fired_next;
    logic [ASSIGNED_W-1:0]  out_assigned_reg, out_assigned_next;
    logic                   out_full_reg, out_full_next;
    logic [ACTIVE_W-1:0]    out_active_reg, out_active_next;

    pett_tmr_ctl_t    tmr_ctl;
    logic             tmr_hit;
    logic             clr_in_range;
    logic [IDX_W-1:0] clr_idx;

    pett_timer_unit #(
        .SLOTS       (SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IDX_W       (IDX_W)
    ) u_timer (
        .clk    (clk),
        .ctl    (tmr_ctl),
        .idx    (idx_reg),
        .period (period_reg),
        .hit    (tmr_hit)
    );

    assign clr_in_range = ({28'd0, slot_reg} < 32'(SLOTS));
    assign clr_idx      = IDX_W'(slot_reg);

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        period_next       = period_reg;
        slot_next         = slot_reg;
        idx_next          = idx_reg;
        active_next       = active_reg;
        total_next        = total_reg;
        fired_next        = fired_reg;
        assigned_next     = assigned_reg;
        full_next         = full_reg;
        out_valid_next    = out_valid_reg;
        out_fired_next    = out_fired_reg;
        out_assigned_next = out_assigned_reg;
        out_full_next     = out_full_reg;
        out_active_next   = out_active_reg;
        tmr_ctl           = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next     = mode_t'(mode);
                    period_next   = COUNT_WIDTH'(period);
                    slot_next     = slot;
                    idx_next      = '0;
                    fired_next    = '0;
                    assigned_next = '0;
                    full_next     = 1'b0;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN:
            begin
                unique case (mode_reg)
                    MODE_TICK:
                    begin
                        if (total_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            if (active_reg[idx_reg])
                            begin
                                tmr_ctl.step = 1'b1;
                                if (tmr_hit)
                                begin
                                    fired_next = fired_reg | (FIRED_W'(1) << idx_reg);
                                end
                            end
                            if (idx_reg == LAST_IDX)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                idx_next = idx_reg + IDX_W'(1);
                            end
                        end
                    end
                    MODE_SET:
                    begin
                        if (!active_reg[idx_reg])
                        begin
                            tmr_ctl.load         = 1'b1;
                            active_next[idx_reg] = 1'b1;
                            total_next           = total_reg + CNT_W'(1);
                            assigned_next        = ASSIGNED_W'(idx_reg);
                            state_next           = ST_DONE;
                        end
                        else if (idx_reg == LAST_IDX)
                        begin
                            full_next  = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    MODE_CLEAR:
                    begin
                        if (clr_in_range && active_reg[clr_idx])
                        begin
                            active_next[clr_idx] = 1'b0;
                            total_next           = total_reg - CNT_W'(1);
                        end
                        state_next = ST_DONE;
                    end
                    MODE_CLEAR_ALL:
                    begin
                        active_next = '0;
                        total_next  = '0;
                        state_next  = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    out_fired_next    = fired_reg;
                    out_assigned_next = assigned_reg;
                    out_full_next     = full_reg;
                    out_active_next   = ACTIVE_W'(total_reg);
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg         <= mode_next;
        period_reg       <= period_next;
        slot_reg         <= slot_next;
        idx_reg          <= idx_next;
        fired_reg        <= fired_next;
        assigned_reg     <= assigned_next;
        full_reg         <= full_next;
        out_fired_reg    <= out_fired_next;
        out_assigned_reg <= out_assigned_next;
        out_full_reg     <= out_full_next;
        out_active_reg   <= out_active_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign fired_mask    = out_fired_reg;
    assign assigned_slot = out_assigned_reg;
    assign table_full    = out_full_reg;
    assign active_slots  = out_active_reg;

endmodule

`default_nettype wire

>>> sv/pett_checker.sv
`default_nettype none

module pett_checker
    import pett_pkg::*;
#(
    parameter int unsigned SLOTS = DEF_SLOTS
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [FIRED_W-1:0]    fired_mask,
    input wire logic [ASSIGNED_W-1:0] assigned_slot,
    input wire logic                  table_full,
    input wire logic [ACTIVE_W-1:0]   active_slots
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fired_mask)
            && $stable(assigned_slot) && $stable(table_full) && $stable(active_slots))
        else $error("Result changed while stalled.");

    a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> assigned_slot == '0)
        else $error("A full table reported a claimed slot.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> active_slots == ACTIVE_W'(SLOTS))
        else $error("A full table reported fewer active slots than exist.");

    a_fired_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired_mask != '0 |-> active_slots != '0
            || SLOTS >= 16)
        else $error("Slots fired while no slot was active.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> SLOTS >= 16 || 32'(active_slots) <= 32'(SLOTS))
        else $error("Active slot count exceeds the table size.");

endmodule

bind periodic_event_timer_table pett_checker #(.SLOTS(SLOTS)) u_pett_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fired_mask    (fired_mask),
    .assigned_slot (assigned_slot),
    .table_full    (table_full),
    .active_slots  (active_slots)
);

`default_nettype wire

>>> verif/timer_table_checker.sv
`timescale 1ns / 100ps

module timer_table_checker
    import pett_pkg::*;
#(
    parameter int unsigned SLOTS = DEF_SLOTS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [MODE_W-1:0]     mode,
    input  logic [PERIOD_W-1:0]   period,
    input  logic [SLOT_ID_W-1:0]  slot,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [FIRED_W-1:0]    fired_mask,
    input  logic [ASSIGNED_W-1:0] assigned_slot,
    input  logic                  table_full,
    input  logic [ACTIVE_W-1:0]   active_slots,
    output int unsigned           mismatches,
    output int unsigned           outstanding
);

    typedef struct packed {
        logic [FIRED_W-1:0]    fired;
        logic [ASSIGNED_W-1:0] assigned;
        logic                  full;
        logic [ACTIVE_W-1:0]   active;
    } timer_result_t;

    logic                       slot_on [SLOTS];
    logic [DEF_COUNT_WIDTH-1:0] reload_val [SLOTS];
    logic [DEF_COUNT_WIDTH-1:0] remaining [SLOTS];
    int unsigned                active_count;
    timer_result_t              expected_results [$];
    timer_result_t              want;
    int unsigned                mismatch_count = 0;
    int unsigned                pending_count = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = pending_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted);
        begin
            $display("%0t: mismatch in %s, got 0x%0h, expected 0x%0h",
                     $time, what, got, wanted);
            mismatch_count++;
        end
    endtask

    function automatic timer_result_t predict_timer_table(input logic [MODE_W-1:0] m,
                                                          input logic [PERIOD_W-1:0] p,
                                                          input logic [SLOT_ID_W-1:0] s);
        timer_result_t r;
        logic          found;
        r     = '0;
        found = 1'b0;
        case (mode_t'(m))
            MODE_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_on[i])
                    begin
                        remaining[i] = remaining[i] - 1'b1;
                        if (remaining[i] == '0)
                        begin
                            if (i < FIRED_W)
                                r.fired[i] = 1'b1;
                            remaining[i] = reload_val[i];
                        end
                    end
                end
            end
            MODE_SET:
            begin
                r.full = 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && !slot_on[i])
                    begin
                        slot_on[i]    = 1'b1;
                        reload_val[i] = DEF_COUNT_WIDTH'(p);
                        remaining[i]  = DEF_COUNT_WIDTH'(p);
                        active_count++;
                        r.assigned    = ASSIGNED_W'(i);
                        r.full        = 1'b0;
                        found         = 1'b1;
                    end
                end
            end
            MODE_CLEAR:
            begin
                if (s < SLOTS && slot_on[s])
                begin
                    slot_on[s] = 1'b0;
                    active_count--;
                end
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                    slot_on[i] = 1'b0;
                active_count = 0;
            end
        endcase
        r.active = ACTIVE_W'(active_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_on[i]    = 1'b0;
                reload_val[i] = '0;
                remaining[i]  = '0;
            end
            active_count = 0;
            expected_results.delete();
            pending_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with no request waiting",
                                    32'({active_slots, table_full, assigned_slot,
                                         fired_mask}),
                                    '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (fired_mask !== want.fired)
                        report_mismatch("fired_mask", 32'(fired_mask), 32'(want.fired));
                    if (assigned_slot !== want.assigned)
                        report_mismatch("assigned_slot", 32'(assigned_slot),
                                        32'(want.assigned));
                    if (table_full !== want.full)
                        report_mismatch("table_full", 32'(table_full), 32'(want.full));
                    if (active_slots !== want.active)
                        report_mismatch("active_slots", 32'(active_slots),
                                        32'(want.active));
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_timer_table(mode, period, slot));
            pending_count = expected_results.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import pett_pkg::*;

    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned RANDOM_COUNT = 1080;
    localparam int unsigned HOLD_CYCLES  = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [MODE_W-1:0]     mode = '0;
    logic [PERIOD_W-1:0]   period = '0;
    logic [SLOT_ID_W-1:0]  slot = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [FIRED_W-1:0]    fired_mask;
    logic [ASSIGNED_W-1:0] assigned_slot;
    logic                  table_full;
    logic [ACTIVE_W-1:0]   active_slots;
    int unsigned           mismatches;
    int unsigned           outstanding;

    int unsigned sent = 0;
    int unsigned taken = 0;
    int unsigned hold_left = 0;
    logic        held_once = 1'b0;
    int unsigned idle_cycles = 0;

    periodic_event_timer_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .period        (period),
        .slot          (slot),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fired_mask    (fired_mask),
        .assigned_slot (assigned_slot),
        .table_full    (table_full),
        .active_slots  (active_slots)
    );

    timer_table_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .period        (period),
        .slot          (slot),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fired_mask    (fired_mask),
        .assigned_slot (assigned_slot),
        .table_full    (table_full),
        .active_slots  (active_slots),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The receiver stalls at random, except for one calm stretch, and holds off
    // once for a long time so that the request side backs up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                taken <= taken + 1;
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!held_once && taken >= 300)
            begin
                held_once <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (taken >= 500 && taken < 700)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("FAIL periodic_event_timer_table");
                    $finish;
                end
            end
        end
    end

    task automatic send_request(input mode_t m, input logic [PERIOD_W-1:0] p,
                                input logic [SLOT_ID_W-1:0] s);
        begin
            while (!(sent >= 500 && sent < 700) && $urandom_range(0, 99) < 35)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            mode     <= m;
            period   <= p;
            slot     <= s;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            sent++;
        end
    endtask

    function automatic logic [PERIOD_W-1:0] pick_period();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(1, 6);
        else if (roll < 85)
            return $urandom_range(7, 40);
        else if (roll < 90)
            return '0;
        else
            return $urandom();
    endfunction

    initial
    begin
        int unsigned roll;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(MODE_TICK, '0, '0);
        send_request(MODE_SET, 32'd1, '0);
        send_request(MODE_SET, 32'd0, '0);
        send_request(MODE_SET, 32'hFFFF_FFFF, 4'hF);
        send_request(MODE_SET, 32'd2, '0);
        send_request(MODE_TICK, '0, '0);
        send_request(MODE_TICK, '0, '0);
        send_request(MODE_SET, 32'd3, '0);
        send_request(MODE_SET, 32'd4, '0);
        send_request(MODE_SET, 32'd5, '0);
        send_request(MODE_SET, 32'h8000_0000, '0);
        send_request(MODE_SET, 32'd7, '0);
        send_request(MODE_TICK, '0, '0);
        send_request(MODE_CLEAR, '0, 4'd15);
        send_request(MODE_CLEAR, '0, 4'd8);
        send_request(MODE_CLEAR, '0, 4'd3);
        send_request(MODE_CLEAR, '0, 4'd3);
        send_request(MODE_SET, 32'h5555_AAAA, '0);
        send_request(MODE_TICK, '0, '0);
        send_request(MODE_CLEAR_ALL, '0, '0);
        send_request(MODE_TICK, '0, '0);
        send_request(MODE_CLEAR, '0, 4'd0);
        send_request(MODE_SET, 32'd1, '0);
        send_request(MODE_TICK, '0, '0);

        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 42)
                send_request(MODE_TICK, $urandom(), SLOT_ID_W'($urandom_range(0, 15)));
            else if (roll < 72)
                send_request(MODE_SET, pick_period(), SLOT_ID_W'($urandom_range(0, 15)));
            else if (roll < 96)
                send_request(MODE_CLEAR, $urandom(),
                             SLOT_ID_W'(($urandom_range(0, 99) < 80)
                                        ? $urandom_range(0, 7)
                                        : $urandom_range(8, 15)));
            else
                send_request(MODE_CLEAR_ALL, $urandom(),
                             SLOT_ID_W'($urandom_range(0, 15)));
        end
        in_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS periodic_event_timer_table");
        else
            $display("FAIL periodic_event_timer_table");
        $finish;
    end

endmodule
